/* design/bpa_pkg.sv */
// Shared definitions for the bitmap page allocator: request kinds, default
// parameter values and the width of the page-number divider.
// No dependencies.
package bpa_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_PAGES_DEF  = 65536;
	localparam int PAGE_BYTES_DEF = 4096;

	// Width of the dividend handed to the page-number divider: a 32-bit base plus
	// a 32-bit length plus a page less one byte never needs more than this.
	localparam int DIV_W = 34;

	// A bitmap byte with every page marked used.
	localparam logic [7:0] BYTE_FULL = 8'hFF;

	typedef enum logic [1:0] {
		KIND_ALLOC       = 2'd0,
		KIND_FREE_PAGE   = 2'd1,
		KIND_LOCK_REGION = 2'd2,
		KIND_FREE_REGION = 2'd3
	} kind_t;

endpackage

/* design/bpa_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/bpa_div.sv */
// Page-number unit for a power-of-two page size: the quotient of a dividend by the
// page size, registered and ready in the cycle after start.
// Depends on bpa_pkg for the dividend width.
module bpa_div
	import bpa_pkg::*;
#(
	parameter int DIVISOR = PAGE_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	localparam int SH = $clog2(DIVISOR);

	logic [DIV_W-1:0] quo_q;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	// The divisor is a power of two, so the quotient is a plain right shift.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend >> SH;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* design/bitmap_page_allocator.sv */
// Bitmap physical page allocator, first fit, built around one bitmap RAM and a
// shared page-number unit under a small sequencer.
// Depends on bpa_pkg, bpa_ram and bpa_div.
//
//   Channel   Direction  Beat contents
//   s_*       in         tuser[1:0] kind; tdata[31:0] address, tdata[63:32] length
//   m_*       out        tdata[31:0] page_address; tuser[0] status (out of memory)
//   cfg_*     in         cfg_data[16:0] page_limit
//
// After reset the block sweeps the bitmap RAM once, writing every one of its
// (MAX_PAGES+7)/8 bytes, 8192 with the defaults, as used; no request is taken
// meanwhile. PAGE_BYTES must be a power of two. Each request holds the input
// off until it is done: an allocate walks the bitmap bytes below the limit, a
// page free takes a page-number step and a walk of its byte (a free of address
// zero does nothing), and a region request takes a page-number step for each end
// of the span, a step to clamp the range to the limit, then a read and the byte
// walk, whose pace the single RAM port pair sets. A finished result sits in the
// output register, so the next request is taken while it waits; a further result
// waits until that register has been emptied.
module bitmap_page_allocator
	import bpa_pkg::*;
#(
	parameter int MAX_PAGES  = MAX_PAGES_DEF,
	parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Request beats.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // address [31:0], length [63:32]
	input  logic [1:0]  s_tuser,   // kind [1:0]
	// Result beats.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // page_address [31:0]
	output logic [0:0]  m_tuser,   // status [0]
	// Page limit register writes.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [16:0] cfg_data   // page_limit [16:0]
);

	localparam int MAP_BYTES = (MAX_PAGES + 7) / 8;
	localparam int AW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam int PIW       = AW + 3;  // page index
	localparam int LW        = AW + 4;  // page count, may equal 2**PIW

	typedef enum logic [7:0] {
		S_CLR  = 8'b0000_0001,
		S_IDLE = 8'b0000_0010,
		S_DIV0 = 8'b0000_0100,
		S_DIV1 = 8'b0000_1000,
		S_RNG  = 8'b0001_0000,
		S_RD   = 8'b0010_0000,
		S_MOD  = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [16:0]      page_limit_q;
	logic [AW-1:0]    clr_q;

	// Request as accepted.
	kind_t            kind_q;
	logic [31:0]      addr_q;
	logic [31:0]      len_q;
	logic [LW-1:0]    lim_q;

	// Page range of the byte walk: pages lo_q up to but not including hi_q.
	logic [DIV_W-1:0] start_q;
	logic [DIV_W-1:0] end_q;
	logic [PIW-1:0]   lo_q;
	logic [LW-1:0]    hi_q;
	logic [AW-1:0]    b_q;
	logic [AW-1:0]    last_q;

	// Result waiting for the output register, and the output register itself.
	logic [31:0]      res_addr_q;
	logic             res_oom_q;
	logic             m_tvalid_q;
	logic [31:0]      m_tdata_q;
	logic             m_tuser_q;

	// Effective page limit, never above MAX_PAGES.
	logic [31:0]      lim_w;
	logic [LW-1:0]    lim_now;
	logic [LW-1:0]    lim_m1;

	// Divider hookup.
	logic             div_start;
	logic [DIV_W-1:0] div_dividend;
	logic             div_done;
	logic [DIV_W-1:0] div_quo;

	// Range set-up.
	logic [DIV_W-1:0] endc;
	logic [DIV_W-1:0] endc_m1;

	// Bitmap RAM hookup.
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [7:0]       ram_wdata;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [7:0]       ram_rdata;

	// Byte walk.
	logic [7:0]       lane_mask;
	logic [7:0]       free_bits;
	logic [7:0]       first_free;
	logic [2:0]       free_idx;
	logic [PIW-1:0]   lane_page;
	logic [PIW-1:0]   alloc_page;
	logic [63:0]      alloc_prod;
	logic             out_free;

	bpa_ram #(
		.WIDTH(8),
		.DEPTH(MAP_BYTES)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	bpa_div #(
		.DIVISOR(PAGE_BYTES)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.done    (div_done),
		.quotient(div_quo)
	);

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;
	assign out_free  = !m_tvalid_q || m_tready;

	always_comb begin
		lim_w   = (32'(page_limit_q) > 32'(MAX_PAGES)) ? 32'(MAX_PAGES) : 32'(page_limit_q);
		lim_now = lim_w[LW-1:0];
		lim_m1  = lim_now - 1'b1;
	end

	// The region end is clamped to the page limit before the walk is set up.
	always_comb begin
		endc    = (end_q > DIV_W'(lim_q)) ? DIV_W'(lim_q) : end_q;
		endc_m1 = endc - 1'b1;
	end

	// Divider is started for the base when a free or region request is taken (not for
	// a free of address zero), and for a region end once the base quotient is back.
	always_comb begin
		div_start    = 1'b0;
		div_dividend = DIV_W'(s_tdata[31:0]);
		if (state_q == S_IDLE && s_tvalid) begin
			div_start = (kind_t'(s_tuser) != KIND_ALLOC) &&
			            !(kind_t'(s_tuser) == KIND_FREE_PAGE && s_tdata[31:0] == 32'd0);
		end else if (state_q == S_DIV0 && div_done && kind_q != KIND_FREE_PAGE) begin
			div_start    = 1'b1;
			div_dividend = DIV_W'(addr_q) + DIV_W'(len_q) + DIV_W'(PAGE_BYTES - 1);
		end
	end

	// Lanes of the current bitmap byte that lie inside the page range. For an
	// allocate the range is every page below the limit.
	always_comb begin
		lane_mask = '0;
		lane_page = '0;
		for (int i = 0; i < 8; i++) begin
			lane_page    = {b_q, 3'(i)};
			lane_mask[i] = (lane_page >= lo_q) && (LW'(lane_page) < hi_q);
		end
	end

	// Lowest free page of the byte.
	always_comb begin
		free_bits  = ~ram_rdata & lane_mask;
		free_idx   = '0;
		for (int i = 7; i >= 0; i--) begin
			if (free_bits[i]) begin
				free_idx = 3'(i);
			end
		end
		first_free = 8'd1 << free_idx;
		alloc_page = {b_q, free_idx};
		alloc_prod = 64'(alloc_page) * 64'(PAGE_BYTES);
	end

	// Bitmap RAM ports: the sweep after reset, and the read-modify-write walk in
	// which the write of one byte and the read of the next share a cycle.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = b_q;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = b_q;
		case (state_q)
			S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = BYTE_FULL;
			end
			S_RD: begin
				ram_re = 1'b1;
			end
			S_MOD: begin
				if (kind_q == KIND_ALLOC) begin
					ram_we    = |free_bits;
					ram_wdata = ram_rdata | first_free;
				end else begin
					ram_we    = 1'b1;
					ram_wdata = (kind_q == KIND_LOCK_REGION) ? (ram_rdata | lane_mask)
					                                         : (ram_rdata & ~lane_mask);
				end
				ram_re    = (b_q != last_q) && !(kind_q == KIND_ALLOC && |free_bits);
				ram_raddr = b_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_q        <= '0;
			page_limit_q <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				page_limit_q <= cfg_data;
			end
			// When the output state reloads the register in the same cycle, the
			// new result keeps it full.
			if (m_tvalid_q && m_tready && state_q != S_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(MAP_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						if (kind_t'(s_tuser) == KIND_ALLOC) begin
							state_q <= (lim_now == '0) ? S_OUT : S_RD;
						end else if (div_start) begin
							state_q <= S_DIV0;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_DIV0: begin
					if (div_done) begin
						state_q <= (kind_q == KIND_FREE_PAGE) ? S_RNG : S_DIV1;
					end
				end
				S_DIV1: begin
					if (div_done) begin
						state_q <= S_RNG;
					end
				end
				S_RNG: begin
					state_q <= (start_q >= endc) ? S_OUT : S_RD;
				end
				S_RD: begin
					state_q <= S_MOD;
				end
				S_MOD: begin
					if (!ram_re) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				kind_q     <= kind_t'(s_tuser);
				addr_q     <= s_tdata[31:0];
				len_q      <= s_tdata[63:32];
				lim_q      <= lim_now;
				res_addr_q <= '0;
				// An allocate starts out reporting out of memory until a free page is found.
				res_oom_q  <= (kind_t'(s_tuser) == KIND_ALLOC);
				lo_q       <= '0;
				hi_q       <= lim_now;
				b_q        <= '0;
				last_q     <= lim_m1[PIW-1:3];
			end
			S_DIV0: begin
				if (div_done) begin
					start_q <= div_quo;
					end_q   <= div_quo + 1'b1;
				end
			end
			S_DIV1: begin
				if (div_done) begin
					end_q <= div_quo;
				end
			end
			S_RNG: begin
				// The walk that uses these runs only when start is below the clamped end.
				lo_q   <= start_q[PIW-1:0];
				hi_q   <= endc[LW-1:0];
				b_q    <= start_q[PIW-1:3];
				last_q <= endc_m1[PIW-1:3];
			end
			S_MOD: begin
				if (kind_q == KIND_ALLOC && |free_bits) begin
					res_addr_q <= alloc_prod[31:0];
					res_oom_q  <= 1'b0;
				end
				if (ram_re) begin
					b_q <= b_q + 1'b1;
				end
			end
			S_OUT: begin
				if (out_free) begin
					m_tdata_q <= res_addr_q;
					m_tuser_q <= res_oom_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
